// ===== rtl/core/bb3_pkg.sv =====
package bb3_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 4096;
  localparam int unsigned CfgWidthBits     = 11;
  localparam int unsigned CfgHeightBits    = 13;
  localparam int unsigned CfgDataBits      = 13;
  localparam int unsigned PixBits          = 24;
  localparam int unsigned ChanBits         = 8;

  typedef enum logic {
    OpPixel = 1'b0,
    OpFlush = 1'b1
  } op_e;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCalc,
    StOut
  } state_e;

  typedef struct packed {
    logic restart;
    logic capture;
    logic shift;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic draining;
    logic result_due;
  } stat_t;

  // (2*sum+count)/(2*count) for count in {1,2,3,4,6,9}; sum <= 9*255
  // reciprocals are exact over the reachable numerator range
  function automatic logic [7:0] round_mean(input logic [11:0] sum, input logic [3:0] cnt);
    logic [12:0] num;
    logic [29:0] prod;
    logic [12:0] q;
    begin
      num  = {sum, 1'b0} + 13'(cnt);
      prod = '0;
      case (cnt)
        4'd1: q = num >> 1;
        4'd2: q = num >> 2;
        4'd3: begin
          prod = num * 14'd10923;
          q    = 13'(prod >> 16);
        end
        4'd4: q = num >> 3;
        4'd6: begin
          prod = num * 14'd5462;
          q    = 13'(prod >> 16);
        end
        default: begin
          prod = num * 14'd7282;
          q    = 13'(prod >> 17);
        end
      endcase
      round_mean = q[7:0];
    end
  endfunction

endpackage

// ===== rtl/core/bb3_ram.sv =====
module bb3_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/bb3_ctrl.sv =====
module bb3_ctrl import bb3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_op_i,
  output logic  in_ready_o,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   drop;

  assign drop = (in_op_i == OpPixel) ? stat_i.draining : !stat_i.draining;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !drop) begin
          cmd_o.capture = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.shift = 1'b1;
        state_d     = stat_i.result_due ? StCalc : StIdle;
      end
      StCalc: state_d = StOut;
      StOut: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == StIdle) else $error("emit not final");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == StRead) else $error("capture lost");

endmodule

// ===== rtl/core/bb3_dp.sv =====
module bb3_dp import bb3_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDefault,
  parameter int unsigned MaxHeight = MaxHeightDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic                     in_op_i,
  input  logic [PixBits-1:0]       in_pix_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CfgDataBits-1:0]   cfg_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [PixBits-1:0]       out_pix_o,
  output logic                     out_last_o
);

  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned CW = $clog2(MaxWidth + 2);
  localparam int unsigned RW = $clog2(MaxHeight + 1);

  logic [CfgWidthBits-1:0]  fw_q;
  logic [CfgHeightBits-1:0] fh_q;
  logic [CW-1:0] w, incol_q, outcol_q, lag_q;
  logic [RW-1:0] h, inrow_q, outrow_q;
  logic [PixBits-1:0] pix_q;
  logic [PixBits-1:0] win_q [3][3];
  logic [PixBits-1:0] up_rd, mid_rd;
  logic [AW-1:0] addr;
  logic [11:0] sum_q [3];
  logic [3:0]  cnt_q;
  logic        last_q;
  logic        kt, kb, kl, kr;

  always_comb begin
    if (fw_q == '0) w = CW'(1);
    else if ({21'd0, fw_q} > 32'(MaxWidth)) w = CW'(MaxWidth);
    else w = CW'(fw_q);
    if (fh_q == '0) h = RW'(1);
    else if ({19'd0, fh_q} > 32'(MaxHeight)) h = RW'(MaxHeight);
    else h = RW'(fh_q);
  end

  assign addr = AW'(incol_q);
  assign stat_o.draining   = inrow_q >= h;
  assign stat_o.result_due = lag_q >= w + CW'(1);

  bb3_ram #(.Width(PixBits), .Depth(MaxWidth)) u_up (
    .clk_i, .we_i(cmd_i.shift), .waddr_i(addr), .wdata_i(mid_rd),
    .raddr_i(addr), .rdata_o(up_rd));
  bb3_ram #(.Width(PixBits), .Depth(MaxWidth)) u_mid (
    .clk_i, .we_i(cmd_i.shift), .waddr_i(addr), .wdata_i(pix_q),
    .raddr_i(addr), .rdata_o(mid_rd));

  assign kt = outrow_q != '0;
  assign kb = outrow_q + RW'(1) < h;
  assign kl = outcol_q != '0;
  assign kr = outcol_q + CW'(1) < w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) pix_q <= (in_op_i == OpFlush) ? '0 : in_pix_i;
    if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_rd;
      win_q[1][2] <= mid_rd;
      win_q[2][2] <= pix_q;
      for (int ch = 0; ch < 3; ch++) begin
        logic [11:0] s;
        s = '0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            logic [PixBits-1:0] p;
            p = (c == 2) ? ((r == 0) ? up_rd : (r == 1) ? mid_rd : pix_q)
                         : win_q[r][c+1];
            if ((r != 0 || kt) && (r != 2 || kb) && (c != 0 || kl) && (c != 2 || kr))
              s = s + 12'(p[16-8*ch +: 8]);
          end
        end
        sum_q[ch] <= s;
      end
      cnt_q <= 4'(({3'd0, kt} + 4'd1 + {3'd0, kb}) * ({3'd0, kl} + 4'd1 + {3'd0, kr}));
      last_q <= !kb && !kr;
    end
    if (cmd_i.emit) begin
      out_pix_o  <= {round_mean(sum_q[0], cnt_q), round_mean(sum_q[1], cnt_q),
                     round_mean(sum_q[2], cnt_q)};
      out_last_o <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= CfgWidthBits'(1024);
      fh_q <= CfgHeightBits'(768);
      incol_q <= '0; inrow_q <= '0; outcol_q <= '0; outrow_q <= '0; lag_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.emit) out_valid_o <= 1'b1;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegFrameWidth) fw_q <= cfg_data_i[CfgWidthBits-1:0];
        else fh_q <= cfg_data_i;
        incol_q <= '0; inrow_q <= '0; outcol_q <= '0; outrow_q <= '0; lag_q <= '0;
      end else if (cmd_i.shift) begin
        if (incol_q + CW'(1) >= w) begin
          incol_q <= '0;
          inrow_q <= inrow_q + RW'(1);
        end else incol_q <= incol_q + CW'(1);
        if (!stat_o.result_due) lag_q <= lag_q + CW'(1);
        else if (!kb && !kr) begin
          incol_q <= '0; inrow_q <= '0; outcol_q <= '0; outrow_q <= '0; lag_q <= '0;
        end else if (!kr) begin
          outcol_q <= '0;
          outrow_q <= outrow_q + RW'(1);
        end else outcol_q <= outcol_q + CW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= w + CW'(1)) else $error("lag overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_o) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit && out_valid_o && !out_ready_i)) else $error("overwrite");

endmodule

// ===== rtl/core/box_blur_3x3_rgb_core.sv =====
// channel | dir | handshake             | payload
// s_axis  | in  | s_axis_tvalid/tready  | tdata: in_red,in_green,in_blue; tuser: op
// m_axis  | out | m_axis_tvalid/tready  | tdata: out_red,out_green,out_blue; tlast
// cfg     | in  | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
// Each item is captured with a line-store read, then shifted into the window and summed;
// when a result is due it also passes a spare state and rounding into the output register,
// which waits for the output to be free.
// Line stores are single-port reads with registered data.
// rst_ni clears control state; line stores are not cleared.
// A held output word stalls the next result but not the next capture.
module box_blur_3x3_rgb_core import bb3_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDefault,
  parameter int unsigned MaxHeight = MaxHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // in_red, in_green, in_blue
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_red, out_green, out_blue
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic [PixBits-1:0] pix_in, pix_out;

  assign cfg_ready_o = 1'b1;
  assign pix_in = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign m_axis_tdata = {pix_out[7:0], pix_out[15:8], pix_out[23:16]};

  bb3_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_op_i(s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .out_free_i(!m_axis_tvalid || m_axis_tready),
    .stat_i(stat), .cmd_o(cmd));

  bb3_dp #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .in_op_i(s_axis_tuser),
    .in_pix_i(pix_in), .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_pix_o(pix_out), .out_last_o(m_axis_tlast));

endmodule

// ===== sim/box_blur_3x3_rgb_core_test.sv =====
module box_blur_3x3_rgb_core_test;
  import bb3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxW = MaxWidthDefault;
  localparam int unsigned MaxH = MaxHeightDefault;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    op_e        op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  box_blur_3x3_rgb_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  pix_word_t  pix_pending[$];
  blur_word_t blur_expect[$];
  int unsigned errors = 0;
  int unsigned n_pixels = 0, n_flushes = 0, n_results = 0, n_frames = 0, n_cfg = 0;
  int unsigned n_items_queued = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit s_fire = 1'b0;
  int unsigned tx_gap = 0, rx_gap = 0;

  // blur predictor state
  logic [23:0] upper_ln [MaxW];
  logic [23:0] middle_ln[MaxW];
  logic [23:0] win[3][3];
  logic [10:0] reg_width = 11'd1024;
  logic [12:0] reg_height = 13'd768;
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0, lag_cnt = 0;

  function automatic int unsigned width_eff();
    if (reg_width < 1) return 1;
    if (reg_width > MaxW) return MaxW;
    return reg_width;
  endfunction

  function automatic int unsigned height_eff();
    if (reg_height < 1) return 1;
    if (reg_height > MaxH) return MaxH;
    return reg_height;
  endfunction

  function automatic void restart_counts();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; lag_cnt = 0;
  endfunction

  // ch: 0 red, 1 green, 2 blue; pixels held as {blue, green, red}
  function automatic logic [7:0] nbhd_mean(int ch, int unsigned w, int unsigned h);
    int unsigned sum = 0, cnt = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if (r == 0 && out_row == 0) continue;
        if (r == 2 && out_row + 1 >= h) continue;
        if (c == 0 && out_col == 0) continue;
        if (c == 2 && out_col + 1 >= w) continue;
        sum += (win[r][c] >> (8 * ch)) & 8'hff;
        cnt++;
      end
    return 8'((2 * sum + cnt) / (2 * cnt));
  endfunction

  function automatic void blur_step(logic [23:0] pix);
    int unsigned w, h, c;
    logic [23:0] col[3];
    blur_word_t exp_word;
    w = width_eff();
    h = height_eff();
    c = in_col;
    if (c >= MaxW) c = 0;
    col[0] = upper_ln[c];
    col[1] = middle_ln[c];
    col[2] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
      win[r][2] = col[r];
    end
    upper_ln[c] = middle_ln[c];
    middle_ln[c] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (lag_cnt < w + 1) begin
      lag_cnt++;
      return;
    end
    exp_word.red   = nbhd_mean(0, w, h);
    exp_word.green = nbhd_mean(1, w, h);
    exp_word.blue  = nbhd_mean(2, w, h);
    exp_word.last  = 1'b0;
    if (out_row + 1 >= h && out_col + 1 >= w) begin
      exp_word.last = 1'b1;
      restart_counts();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    blur_expect.push_back(exp_word);
  endfunction

  function automatic void take_word(op_e op, logic [23:0] data);
    bit draining;
    draining = in_row >= height_eff();
    if (op == OpPixel) begin
      n_pixels++;
      if (!draining) blur_step(data);
    end else begin
      n_flushes++;
      if (draining) blur_step(24'h0);
    end
  endfunction

  initial begin
    for (int i = 0; i < MaxW; i++) begin
      upper_ln[i] = '0;
      middle_ln[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    blur_word_t exp_word;
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      take_word(op_e'(s_axis_tuser), s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (blur_expect.size() == 0) begin
        $error("unexpected output word %h last %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        exp_word = blur_expect.pop_front();
        if (m_axis_tlast) n_frames++;
        if (m_axis_tdata[7:0] !== exp_word.red) begin
          $error("out_red: expected %0d, got %0d", exp_word.red, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== exp_word.green) begin
          $error("out_green: expected %0d, got %0d", exp_word.green, m_axis_tdata[15:8]);
          errors++;
        end
        if (m_axis_tdata[23:16] !== exp_word.blue) begin
          $error("out_blue: expected %0d, got %0d", exp_word.blue, m_axis_tdata[23:16]);
          errors++;
        end
        if (m_axis_tlast !== exp_word.last) begin
          $error("frame_last: expected %0d, got %0d", exp_word.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // pixel driver
  always @(negedge clk_i) begin
    pix_word_t nxt;
    if (rst_ni && !(s_axis_tvalid && !s_fire)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pix_pending.size() > 0) begin
        nxt = pix_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= nxt.op;
        s_axis_tdata <= {nxt.blue, nxt.green, nxt.red};
        if (!quiet && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 10);
      end
    end
  end

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_word(op_e op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_word_t w;
    w.op = op; w.red = r; w.green = g; w.blue = b;
    pix_pending.push_back(w);
    n_items_queued++;
  endfunction

  function automatic void queue_rand(op_e op);
    queue_word(op, rand_chan(), rand_chan(), rand_chan());
  endfunction

  // full frame, then the drain flushes; optional stray flushes and pixels that are ignored
  function automatic void queue_frame(int unsigned w, int unsigned h, bit noisy);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) queue_rand(OpFlush);
      queue_rand(OpPixel);
    end
    for (int unsigned j = 0; j <= w; j++) begin
      queue_rand(OpFlush);
      if (noisy && j < w && $urandom_range(0, 5) == 0) queue_rand(OpPixel);
    end
  endfunction

  task automatic settle();
    while (pix_pending.size() > 0 || s_axis_tvalid || blur_expect.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegFrameWidth) reg_width = val[10:0];
    else reg_height = val[12:0];
    restart_counts();
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(logic [CfgDataBits-1:0] w, logic [CfgDataBits-1:0] h);
    settle();
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
  endtask

  initial begin
    int unsigned w, h;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 3x3 frame with extreme values, early flush, pixel while draining
    set_size(3, 3);
    queue_word(OpFlush, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 9; i++)
      if (i % 2 == 0) queue_word(OpPixel, 8'hff, 8'hff, 8'hff);
      else queue_word(OpPixel, 8'h00, 8'h00, 8'h00);
    queue_word(OpFlush, 8'h00, 8'h00, 8'h00);
    queue_word(OpPixel, 8'hff, 8'h00, 8'hff);
    for (int i = 0; i < 3; i++) queue_word(OpFlush, 8'hff, 8'hff, 8'hff);
    queue_word(OpPixel, 8'h12, 8'h34, 8'h56);
    settle();

    // size registers at and beyond their limits
    set_size(0, 0);
    queue_frame(1, 1, 1'b1);
    set_size(1, 8191);
    for (int i = 0; i < 12; i++) queue_rand(OpPixel);
    set_size(2047, 1);
    for (int i = 0; i < 20; i++) queue_rand(OpPixel);
    set_size(1024, 4096);
    for (int i = 0; i < 20; i++) queue_rand(OpPixel);
    set_size(2, 1);
    queue_frame(2, 1, 1'b0);
    settle();

    // random frames, some cut short by a size change
    while (n_items_queued < 800) begin
      if (n_items_queued > 650) quiet = 1'b1;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) set_size(w, h);
      else if ($urandom_range(0, 1) == 0) begin
        settle();
        write_reg(RegFrameWidth, w);
        h = height_eff();
        if (h > 8) begin
          write_reg(RegFrameHeight, 8);
          h = 8;
        end
      end else begin
        settle();
        write_reg(RegFrameHeight, h);
        w = width_eff();
      end
      if ($urandom_range(0, 5) == 0) begin
        for (int unsigned i = $urandom_range(1, w * h); i > 0; i--) queue_rand(OpPixel);
      end else begin
        repeat ($urandom_range(1, 3)) queue_frame(w, h, 1'b1);
      end
    end
    settle();

    $display("sent %0d pixels and %0d flushes over %0d size writes", n_pixels, n_flushes,
             n_cfg);
    $display("checked %0d output words, %0d frame ends", n_results, n_frames);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
